// ----- src/lmsg_pkg.sv -----
// Package for the linear move step generator: payload types, codes and constants.
package lmsg_pkg;

    // Field widths
    localparam int POS_W   = 24;
    localparam int DIST_W  = 25;
    localparam int LEN_W   = 40;
    localparam int RAMP_W  = 32;
    localparam int RT_W    = 24;
    localparam int TPS_W   = 16;
    localparam int DT_W    = 16;
    localparam int SPEED_W = 7;
    localparam int MD_A_W  = 24;
    localparam int MD_N_W  = 5;

    // Full speed in percent
    localparam logic [SPEED_W-1:0] FULL_SPEED = 7'd100;

    // Register reset values
    localparam logic [RT_W-1:0]  RAMP_TIME_RST = 24'd100000;
    localparam logic [TPS_W-1:0] TPS_RST       = 16'd1500;
    localparam logic             ABS_DEF_RST   = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_RAMP_TIME     = 2'd0;
    localparam logic [1:0] CFG_TIME_PER_STEP = 2'd1;
    localparam logic [1:0] CFG_ABS_DEFAULT   = 2'd2;

    // Request codes
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    // Positioning codes
    localparam logic [1:0] POS_DEFAULT  = 2'd0;
    localparam logic [1:0] POS_ABSOLUTE = 2'd1;
    localparam logic [1:0] POS_RELATIVE = 2'd2;

    // Status codes
    localparam logic STATUS_RUN  = 1'b0;
    localparam logic STATUS_DONE = 1'b1;

    typedef struct packed {
        logic                    req_type;
        logic [1:0]              positioning;
        logic signed [POS_W-1:0] target_x;
        logic signed [POS_W-1:0] target_y;
        logic signed [POS_W-1:0] target_z;
        logic [DT_W-1:0]         elapsed_us;
    } t_in_item;

    typedef struct packed {
        logic                    move_status;
        logic [2:0]              step_mask;
        logic [2:0]              dir_mask;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
    } t_out_item;

    // Request to the multiply-divide unit: floor(a * b / c), b <= c,
    // a left-aligned with nbits significant bits
    typedef struct packed {
        logic [MD_A_W-1:0] a;
        logic [MD_N_W-1:0] nbits;
        logic [LEN_W-1:0]  b;
        logic [LEN_W-1:0]  c;
    } t_md_req;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LEN,
        ST_SPEED,
        ST_SPEED_WAIT,
        ST_PROG_START,
        ST_PROG_WAIT,
        ST_AXIS_START,
        ST_AXIS_WAIT,
        ST_DONE
    } t_state;

endpackage

// ----- src/linear_move_step_generator_top.sv -----
// Top level of the three-axis linear move step generator with speed ramp.
//
// Each input beat gives exactly one result beat. A start beat runs through accept,
// move length multiply and result. A tick beat during a move runs the speed (while
// it is still ramping), progress and every axis position each through one shared
// multiply-divide unit that resolves one quotient digit per cycle (7, 16 and 24
// digits). Once the ramp is over the speed division is skipped. A tick while idle
// goes straight to the result. The input stalls until the result is loaded into
// the output register; a finished result waits there while the next beat is
// already being worked on. Configuration writes are always ready and take effect
// at once.
module linear_move_step_generator_top #(
    parameter int AXES = 3
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  lmsg_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output lmsg_pkg::t_out_item  o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [23:0]          i_cfg_data
);

    localparam int AX_W = (AXES > 1) ? $clog2(AXES) : 1;
    localparam int PW   = lmsg_pkg::POS_W;
    localparam int DW   = lmsg_pkg::DIST_W;
    localparam int LW   = lmsg_pkg::LEN_W;
    localparam int RW   = lmsg_pkg::RAMP_W;
    localparam int AW   = lmsg_pkg::MD_A_W;
    localparam int SW   = lmsg_pkg::SPEED_W;
    localparam int TW   = lmsg_pkg::TPS_W;
    localparam int DTW  = lmsg_pkg::DT_W;

    // Configuration
    logic [lmsg_pkg::RT_W-1:0] r_ramp_time;
    logic [TW-1:0]             r_tps;
    logic                      r_abs_default;

    // Move state
    lmsg_pkg::t_state  r_state;
    lmsg_pkg::t_state  n_state;
    logic signed [PW-1:0] r_pos   [AXES];
    logic signed [PW-1:0] r_start [AXES];
    logic signed [DW-1:0] r_dist  [AXES];
    logic                 r_par   [AXES];
    logic [LW-1:0]        r_progress;
    logic [LW-1:0]        r_move_length;
    logic [RW-1:0]        r_ramp_elapsed;
    logic                 r_active;
    logic [DTW-1:0]       r_dt;
    logic [SW-1:0]        r_speed;
    logic [AX_W-1:0]      r_axis;
    logic [2:0]           r_steps;

    // Output register
    logic                 r_out_valid;
    lmsg_pkg::t_out_item  r_out_data;

    // Shared unit
    logic                 w_md_start;
    lmsg_pkg::t_md_req    w_md_req;
    logic                 w_md_done;
    logic [AW-1:0]        w_md_quot;

    logic                 w_accept;
    logic                 w_absolute;
    logic signed [PW-1:0] w_tgt_in [3];
    logic signed [DW-1:0] w_new_dist [AXES];
    logic [PW-1:0]        w_maxd;
    logic [LW-1:0]        w_len;
    logic [RW:0]          w_ramp_sum;
    logic [LW:0]          w_prog_sum;
    logic [TW-1:0]        w_prog_step;
    logic signed [DW-1:0] w_cur_dist;
    logic [PW-1:0]        w_cur_mag;
    logic signed [DW-1:0] w_new_pos;
    logic signed [PW-1:0] w_pos_out [3];
    logic [2:0]           w_dir;
    logic                 w_out_free;

    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != lmsg_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp_time   <= lmsg_pkg::RAMP_TIME_RST;
            r_tps         <= lmsg_pkg::TPS_RST;
            r_abs_default <= lmsg_pkg::ABS_DEF_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                lmsg_pkg::CFG_RAMP_TIME:     r_ramp_time   <= i_cfg_data;
                lmsg_pkg::CFG_TIME_PER_STEP: r_tps         <= i_cfg_data[TW-1:0];
                lmsg_pkg::CFG_ABS_DEFAULT:   r_abs_default <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Start beat: target per axis, saturating for relative moves
    assign w_tgt_in[0] = i_in_data.target_x;
    assign w_tgt_in[1] = i_in_data.target_y;
    assign w_tgt_in[2] = i_in_data.target_z;

    always_comb begin
        case (i_in_data.positioning)
            lmsg_pkg::POS_ABSOLUTE: w_absolute = 1'b1;
            lmsg_pkg::POS_RELATIVE: w_absolute = 1'b0;
            default:                w_absolute = r_abs_default;
        endcase
    end

    for (genvar g = 0; g < AXES; g++) begin : g_lane
        if (g < 3) begin : g_tgt
            logic signed [DW-1:0] w_sum;
            logic signed [PW-1:0] w_tgt;
            always_comb begin
                w_sum = DW'(r_pos[g]) + DW'(w_tgt_in[g]);
                if (w_absolute) begin
                    w_tgt = w_tgt_in[g];
                end else if (w_sum[DW-1] != w_sum[DW-2]) begin
                    w_tgt = w_sum[DW-1] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
                end else begin
                    w_tgt = w_sum[PW-1:0];
                end
                w_new_dist[g] = DW'(w_tgt) - DW'(r_pos[g]);
            end
        end else begin : g_none
            assign w_new_dist[g] = '0;
        end
    end

    // Longest axis distance and move length
    always_comb begin
        logic [DW-1:0] mag;
        w_maxd = '0;
        for (int i = 0; i < AXES; i++) begin
            mag = r_dist[i][DW-1] ? -r_dist[i] : r_dist[i];
            if (mag[PW-1:0] > w_maxd) w_maxd = mag[PW-1:0];
        end
        w_len = LW'(w_maxd) * LW'(r_tps);
    end

    // Ramp timer, saturating
    assign w_ramp_sum = {1'b0, r_ramp_elapsed} + (RW + 1)'(i_in_data.elapsed_us);

    // Progress step clamped at time per step, progress clamped at the move length
    always_comb begin
        w_prog_step = (w_md_quot[TW-1:0] > r_tps) ? r_tps : w_md_quot[TW-1:0];
        w_prog_sum  = {1'b0, r_progress} + (LW + 1)'(w_prog_step);
    end

    // Current axis: distance magnitude and interpolated position
    always_comb begin
        logic [DW-1:0] mag;
        logic signed [DW-1:0] off;
        w_cur_dist = r_dist[r_axis];
        mag        = w_cur_dist[DW-1] ? -w_cur_dist : w_cur_dist;
        w_cur_mag  = mag[PW-1:0];
        off        = DW'(w_md_quot);
        w_new_pos  = w_cur_dist[DW-1] ? DW'(r_start[r_axis]) - off
                                      : DW'(r_start[r_axis]) + off;
    end

    // Sequencer: next state and shared-unit requests
    always_comb begin
        n_state    = r_state;
        w_md_start = 1'b0;
        w_md_req   = '0;
        case (r_state)
            lmsg_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (i_in_data.req_type == lmsg_pkg::REQ_START) n_state = lmsg_pkg::ST_LEN;
                    else if (r_active)                              n_state = lmsg_pkg::ST_SPEED;
                    else                                            n_state = lmsg_pkg::ST_DONE;
                end
            end
            lmsg_pkg::ST_LEN: n_state = lmsg_pkg::ST_DONE;
            lmsg_pkg::ST_SPEED: begin
                if (r_ramp_elapsed < RW'(r_ramp_time)) begin
                    w_md_start     = 1'b1;
                    w_md_req.a     = AW'(lmsg_pkg::FULL_SPEED) << (AW - SW);
                    w_md_req.nbits = lmsg_pkg::MD_N_W'(SW);
                    w_md_req.b     = LW'(r_ramp_elapsed[lmsg_pkg::RT_W-1:0]);
                    w_md_req.c     = LW'(r_ramp_time);
                    n_state        = lmsg_pkg::ST_SPEED_WAIT;
                end else begin
                    n_state = lmsg_pkg::ST_PROG_START;
                end
            end
            lmsg_pkg::ST_SPEED_WAIT: begin
                if (w_md_done) n_state = lmsg_pkg::ST_PROG_START;
            end
            lmsg_pkg::ST_PROG_START: begin
                w_md_start     = 1'b1;
                w_md_req.a     = AW'(r_dt) << (AW - DTW);
                w_md_req.nbits = lmsg_pkg::MD_N_W'(DTW);
                w_md_req.b     = LW'(r_speed);
                w_md_req.c     = LW'(lmsg_pkg::FULL_SPEED);
                n_state        = lmsg_pkg::ST_PROG_WAIT;
            end
            lmsg_pkg::ST_PROG_WAIT: begin
                if (w_md_done) n_state = lmsg_pkg::ST_AXIS_START;
            end
            lmsg_pkg::ST_AXIS_START: begin
                w_md_start     = 1'b1;
                w_md_req.a     = w_cur_mag;
                w_md_req.nbits = lmsg_pkg::MD_N_W'(AW);
                w_md_req.b     = r_progress;
                w_md_req.c     = r_move_length;
                n_state        = lmsg_pkg::ST_AXIS_WAIT;
            end
            lmsg_pkg::ST_AXIS_WAIT: begin
                if (w_md_done) begin
                    if (r_axis == AX_W'(AXES - 1)) n_state = lmsg_pkg::ST_DONE;
                    else                           n_state = lmsg_pkg::ST_AXIS_START;
                end
            end
            lmsg_pkg::ST_DONE: begin
                if (w_out_free) n_state = lmsg_pkg::ST_IDLE;
            end
            default: n_state = lmsg_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= lmsg_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    // Move state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < AXES; i++) begin
                r_pos[i]   <= '0;
                r_start[i] <= '0;
                r_dist[i]  <= '0;
                r_par[i]   <= 1'b0;
            end
            r_progress     <= '0;
            r_move_length  <= '0;
            r_ramp_elapsed <= '0;
            r_active       <= 1'b0;
            r_axis         <= '0;
            r_steps        <= '0;
        end else begin
            case (r_state)
                lmsg_pkg::ST_IDLE: begin
                    if (w_accept) begin
                        r_steps <= '0;
                        r_axis  <= '0;
                        if (i_in_data.req_type == lmsg_pkg::REQ_START) begin
                            for (int i = 0; i < AXES; i++) begin
                                r_start[i] <= r_pos[i];
                                r_dist[i]  <= w_new_dist[i];
                                r_par[i]   <= r_pos[i][0];
                            end
                        end else if (r_active) begin
                            r_ramp_elapsed <= w_ramp_sum[RW] ? '1 : w_ramp_sum[RW-1:0];
                        end
                    end
                end
                lmsg_pkg::ST_LEN: begin
                    r_move_length  <= w_len;
                    r_progress     <= '0;
                    r_ramp_elapsed <= '0;
                    r_active       <= (w_len != '0);
                end
                lmsg_pkg::ST_PROG_WAIT: begin
                    if (w_md_done) begin
                        r_progress <= (w_prog_sum > {1'b0, r_move_length})
                                      ? r_move_length : w_prog_sum[LW-1:0];
                    end
                end
                lmsg_pkg::ST_AXIS_WAIT: begin
                    if (w_md_done) begin
                        r_pos[r_axis] <= w_new_pos[PW-1:0];
                        if (w_new_pos[0] != r_par[r_axis]) begin
                            r_par[r_axis] <= w_new_pos[0];
                            for (int k = 0; k < 3; k++) begin
                                if (int'(r_axis) == k) r_steps[k] <= 1'b1;
                            end
                        end
                        if (r_axis == AX_W'(AXES - 1)) r_active <= (r_progress < r_move_length);
                        else                           r_axis   <= r_axis + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Tick payload: elapsed time and speed
    always_ff @(posedge i_clk) begin
        if (w_accept) r_dt <= i_in_data.elapsed_us;
        if (r_state == lmsg_pkg::ST_SPEED) r_speed <= lmsg_pkg::FULL_SPEED;
        else if (r_state == lmsg_pkg::ST_SPEED_WAIT && w_md_done) r_speed <= w_md_quot[SW-1:0];
    end

    // Direction bits and position fields
    for (genvar k = 0; k < 3; k++) begin : g_outlane
        if (k < AXES) begin : g_on
            assign w_pos_out[k] = r_pos[k];
            assign w_dir[k]     = !r_dist[k][DW-1] && (r_dist[k] != '0);
        end else begin : g_off
            assign w_pos_out[k] = '0;
            assign w_dir[k]     = 1'b0;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == lmsg_pkg::ST_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == lmsg_pkg::ST_DONE && w_out_free) begin
            r_out_data.move_status <= r_active ? lmsg_pkg::STATUS_RUN : lmsg_pkg::STATUS_DONE;
            r_out_data.step_mask   <= r_steps;
            r_out_data.dir_mask    <= w_dir;
            r_out_data.pos_x       <= w_pos_out[0];
            r_out_data.pos_y       <= w_pos_out[1];
            r_out_data.pos_z       <= w_pos_out[2];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    lmsg_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_md_start),
        .i_req   (w_md_req),
        .o_done  (w_md_done),
        .o_quot  (w_md_quot)
    );

    // Checks
    a_md_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_md_done |-> (r_state == lmsg_pkg::ST_SPEED_WAIT || r_state == lmsg_pkg::ST_PROG_WAIT
                       || r_state == lmsg_pkg::ST_AXIS_WAIT))
        else $error("multiply-divide result arrived outside a wait state");

    a_prog_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_progress <= r_move_length)
        else $error("progress passed the move length");

    a_active_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_move_length != '0))
        else $error("move active with zero length");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == lmsg_pkg::ST_DONE))
        else $error("result beat loaded outside the done state");

endmodule

// ----- src/lmsg_muldiv.sv -----
// Shared multiply-divide unit: floor(a*b/c) with one quotient digit per cycle.
module lmsg_muldiv (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  lmsg_pkg::t_md_req                 i_req,
    output logic                              o_done,
    output logic [lmsg_pkg::MD_A_W-1:0]       o_quot
);

    localparam int AW = lmsg_pkg::MD_A_W;
    localparam int CW = lmsg_pkg::LEN_W;

    logic                          r_busy;
    logic                          r_done;
    logic [lmsg_pkg::MD_N_W-1:0]   r_cnt;
    logic [AW-1:0]                 r_a;
    logic [CW-1:0]                 r_b;
    logic [CW-1:0]                 r_c;
    logic [CW-1:0]                 r_rem;
    logic [AW-1:0]                 r_quot;

    logic [CW+1:0] w_sum;
    logic [CW+1:0] w_c1;
    logic [CW+1:0] w_c2;
    logic [CW+1:0] w_rem;
    logic [1:0]    w_digit;
    logic [AW-1:0] w_quot;

    // One step: rem = 2*rem + bit*b, then take out 0, 1 or 2 times c (rem stays below c)
    always_comb begin
        w_sum = {1'b0, r_rem, 1'b0} + ((r_a[AW-1]) ? {2'b00, r_b} : '0);
        w_c1  = {2'b00, r_c};
        w_c2  = {1'b0, r_c, 1'b0};
        if (w_sum >= w_c2) begin
            w_digit = 2'd2;
            w_rem   = w_sum - w_c2;
        end else if (w_sum >= w_c1) begin
            w_digit = 2'd1;
            w_rem   = w_sum - w_c1;
        end else begin
            w_digit = 2'd0;
            w_rem   = w_sum;
        end
        w_quot = {r_quot[AW-2:0], 1'b0} + AW'(w_digit);
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.nbits;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == lmsg_pkg::MD_N_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a    <= i_req.a;
            r_b    <= i_req.b;
            r_c    <= i_req.c;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_a    <= {r_a[AW-2:0], 1'b0};
            r_rem  <= w_rem[CW-1:0];
            r_quot <= w_quot;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule
